>>> hw/rtl/vmd_pkg.sv
// ----------------------------------------------------------------------------
// vmd_pkg
// shared types, sizes and codes of the volume mip downsampler
// ----------------------------------------------------------------------------
package vmd_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_DEPTH  = 128;

    localparam int CFG_W = 8;

    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;

    // parent position widths and size widths
    localparam int PX_W  = $clog2(MAX_WIDTH);
    localparam int PY_W  = $clog2(MAX_HEIGHT);
    localparam int PZ_W  = $clog2(MAX_DEPTH);
    localparam int SX_W  = $clog2(MAX_WIDTH + 1);
    localparam int SY_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W  = $clog2(MAX_DEPTH + 1);

    // child index widths
    localparam int CX_W  = (HALF_W > 1) ? $clog2(HALF_W) : 1;
    localparam int CY_W  = (HALF_H > 1) ? $clog2(HALF_H) : 1;
    localparam int CZ_W  = (PZ_W > 1) ? PZ_W - 1 : 1;
    localparam int PA_W  = (HALF_W * HALF_H > 1) ? $clog2(HALF_W * HALF_H) : 1;

    // partial sum widths
    localparam int XP_W  = 10;
    localparam int HX_W  = 11;
    localparam int HY_W  = 13;
    localparam int SUM_W = 15;

    localparam int COORD_W = 6;
    localparam int VAL_W   = 8;

    // reciprocal of 125 scaled by 2**22
    localparam int RSH   = 22;
    localparam int RCP_W = 16;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(33555);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    typedef enum logic [1:0] {
        ROLE_NONE   = 2'd0,
        ROLE_EVEN   = 2'd1,
        ROLE_SINGLE = 2'd2,
        ROLE_ODD    = 2'd3
    } t_role;

    typedef struct packed {
        logic            act;
        logic [CX_W-1:0] cx;
    } t_rowrd;

    typedef struct packed {
        logic            act;
        logic [HX_W-1:0] hx;
        logic [CX_W-1:0] cx;
        logic [CY_W-1:0] cy;
        logic [CZ_W-1:0] cz;
        t_role           ry;
        t_role           rz;
        logic            y0;
        logic            z0;
        logic            last;
    } t_s1;

    typedef struct packed {
        logic            act;
        logic [HY_W-1:0] hy;
        logic [PA_W-1:0] paddr;
        logic [CX_W-1:0] cx;
        logic [CY_W-1:0] cy;
        logic [CZ_W-1:0] cz;
        t_role           rz;
        logic            z0;
        logic            last;
    } t_s2;

    typedef struct packed {
        logic             act;
        logic [SUM_W-1:0] sum;
        logic [CX_W-1:0]  cx;
        logic [CY_W-1:0]  cy;
        logic [CZ_W-1:0]  cz;
        logic             last;
    } t_s3;

endpackage

>>> hw/rtl/vmd_in_if.sv
// ----------------------------------------------------------------------------
// vmd_in_if
// parent voxel request channel
// ----------------------------------------------------------------------------
interface vmd_in_if;
    logic                      valid;
    logic                      ready;
    logic [vmd_pkg::VAL_W-1:0] voxel;
    logic                      volume_start;

    modport source (output valid, output voxel, output volume_start, input ready);
    modport sink   (input valid, input voxel, input volume_start, output ready);
endinterface

>>> hw/rtl/vmd_out_if.sv
// ----------------------------------------------------------------------------
// vmd_out_if
// child voxel request channel
// ----------------------------------------------------------------------------
interface vmd_out_if;
    logic                        valid;
    logic                        ready;
    logic [vmd_pkg::VAL_W-1:0]   child_value;
    logic [vmd_pkg::VAL_W-1:0]   inverted_value;
    logic [vmd_pkg::COORD_W-1:0] out_x;
    logic [vmd_pkg::COORD_W-1:0] out_y;
    logic [vmd_pkg::COORD_W-1:0] out_z;
    logic                        last_of_volume;

    modport source (output valid, output child_value, output inverted_value,
                    output out_x, output out_y, output out_z, output last_of_volume,
                    input ready);
    modport sink   (input valid, input child_value, input inverted_value,
                    input out_x, input out_y, input out_z, input last_of_volume,
                    output ready);
endinterface

>>> hw/rtl/vmd_ram.sv
// ----------------------------------------------------------------------------
// vmd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/vmd_front.sv
// ----------------------------------------------------------------------------
// vmd_front
// size registers, parent position tracking and x filter stage
// ----------------------------------------------------------------------------
module vmd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [vmd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_acc,
    input  logic                        i_adv,
    input  logic [vmd_pkg::VAL_W-1:0]   i_voxel,
    input  logic                        i_start,
    output vmd_pkg::t_rowrd             o_rowrd,
    output vmd_pkg::t_s1                o_s1
);
    logic [vmd_pkg::CFG_W-1:0] r_pw, r_ph, r_pd;
    logic [vmd_pkg::PX_W-1:0]  r_px, n_px;
    logic [vmd_pkg::PY_W-1:0]  r_py, n_py;
    logic [vmd_pkg::PZ_W-1:0]  r_pz, n_pz;
    logic [vmd_pkg::XP_W-1:0]  r_xpart, n_xpart;
    logic [vmd_pkg::VAL_W-1:0] r_xodd, n_xodd;
    vmd_pkg::t_s1              r_s1, n_s1;

    logic [vmd_pkg::SX_W-1:0] pw, cw;
    logic [vmd_pkg::SY_W-1:0] ph, ch;
    logic [vmd_pkg::SZ_W-1:0] pd, cd;
    logic [vmd_pkg::PX_W-1:0] px;
    logic [vmd_pkg::PY_W-1:0] py;
    logic [vmd_pkg::PZ_W-1:0] pz;
    logic [vmd_pkg::CX_W-1:0] cx;
    logic [vmd_pkg::CY_W-1:0] cy;
    logic [vmd_pkg::CZ_W-1:0] cz;
    vmd_pkg::t_role           rx, ry, rz;
    logic [vmd_pkg::HX_W-1:0] hx;
    logic                     x_done;

    always_comb begin
        pw = (r_pw == '0) ? vmd_pkg::SX_W'(1) :
             ((32'(r_pw) > vmd_pkg::MAX_WIDTH) ? vmd_pkg::SX_W'(vmd_pkg::MAX_WIDTH)
                                               : vmd_pkg::SX_W'(r_pw));
        ph = (r_ph == '0) ? vmd_pkg::SY_W'(1) :
             ((32'(r_ph) > vmd_pkg::MAX_HEIGHT) ? vmd_pkg::SY_W'(vmd_pkg::MAX_HEIGHT)
                                                : vmd_pkg::SY_W'(r_ph));
        pd = (r_pd == '0) ? vmd_pkg::SZ_W'(1) :
             ((32'(r_pd) > vmd_pkg::MAX_DEPTH) ? vmd_pkg::SZ_W'(vmd_pkg::MAX_DEPTH)
                                               : vmd_pkg::SZ_W'(r_pd));
        cw = ((pw >> 1) == '0) ? vmd_pkg::SX_W'(1) : (pw >> 1);
        ch = ((ph >> 1) == '0) ? vmd_pkg::SY_W'(1) : (ph >> 1);
        cd = ((pd >> 1) == '0) ? vmd_pkg::SZ_W'(1) : (pd >> 1);

        px = i_start ? '0 : r_px;
        py = i_start ? '0 : r_py;
        pz = i_start ? '0 : r_pz;
        if (vmd_pkg::SX_W'(px) >= pw) px = '0;
        if (vmd_pkg::SY_W'(py) >= ph) py = '0;
        if (vmd_pkg::SZ_W'(pz) >= pd) pz = '0;

        // axis roles
        cx = vmd_pkg::CX_W'(px >> 1);
        if (pw == vmd_pkg::SX_W'(1)) begin
            cx = '0;
            rx = vmd_pkg::ROLE_SINGLE;
        end else if (vmd_pkg::SX_W'(px >> 1) >= cw) begin
            rx = vmd_pkg::ROLE_NONE;
        end else begin
            rx = px[0] ? vmd_pkg::ROLE_ODD : vmd_pkg::ROLE_EVEN;
        end
        cy = vmd_pkg::CY_W'(py >> 1);
        if (ph == vmd_pkg::SY_W'(1)) begin
            cy = '0;
            ry = vmd_pkg::ROLE_SINGLE;
        end else if (vmd_pkg::SY_W'(py >> 1) >= ch) begin
            ry = vmd_pkg::ROLE_NONE;
        end else begin
            ry = py[0] ? vmd_pkg::ROLE_ODD : vmd_pkg::ROLE_EVEN;
        end
        cz = vmd_pkg::CZ_W'(pz >> 1);
        if (pd == vmd_pkg::SZ_W'(1)) begin
            cz = '0;
            rz = vmd_pkg::ROLE_SINGLE;
        end else if (vmd_pkg::SZ_W'(pz >> 1) >= cd) begin
            rz = vmd_pkg::ROLE_NONE;
        end else begin
            rz = pz[0] ? vmd_pkg::ROLE_ODD : vmd_pkg::ROLE_EVEN;
        end

        // x stage
        n_xpart = r_xpart;
        n_xodd  = r_xodd;
        hx      = '0;
        x_done  = 1'b0;
        case (rx)
            vmd_pkg::ROLE_SINGLE: begin
                hx     = vmd_pkg::HX_W'(i_voxel) * vmd_pkg::HX_W'(5);
                x_done = 1'b1;
            end
            vmd_pkg::ROLE_EVEN: begin
                n_xpart = (px == '0) ? vmd_pkg::XP_W'(i_voxel) << 2 :
                          vmd_pkg::XP_W'(r_xodd) + vmd_pkg::XP_W'(i_voxel) * vmd_pkg::XP_W'(3);
            end
            vmd_pkg::ROLE_ODD: begin
                hx     = vmd_pkg::HX_W'(r_xpart) + vmd_pkg::HX_W'(i_voxel);
                n_xodd = i_voxel;
                x_done = 1'b1;
            end
            default: begin
                x_done = 1'b0;
            end
        endcase

        // next position
        n_px = px;
        n_py = py;
        n_pz = pz;
        if (vmd_pkg::SX_W'(px) + vmd_pkg::SX_W'(1) < pw) begin
            n_px = px + vmd_pkg::PX_W'(1);
        end else begin
            n_px = '0;
            if (vmd_pkg::SY_W'(py) + vmd_pkg::SY_W'(1) < ph) begin
                n_py = py + vmd_pkg::PY_W'(1);
            end else begin
                n_py = '0;
                if (vmd_pkg::SZ_W'(pz) + vmd_pkg::SZ_W'(1) < pd) begin
                    n_pz = pz + vmd_pkg::PZ_W'(1);
                end else begin
                    n_pz = '0;
                end
            end
        end

        n_s1.act  = i_acc && x_done;
        n_s1.hx   = hx;
        n_s1.cx   = cx;
        n_s1.cy   = cy;
        n_s1.cz   = cz;
        n_s1.ry   = ry;
        n_s1.rz   = rz;
        n_s1.y0   = (py == '0);
        n_s1.z0   = (pz == '0);
        n_s1.last = (vmd_pkg::SX_W'(cx) == cw - vmd_pkg::SX_W'(1)) &&
                    (vmd_pkg::SY_W'(cy) == ch - vmd_pkg::SY_W'(1)) &&
                    (vmd_pkg::SZ_W'(cz) == cd - vmd_pkg::SZ_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw    <= vmd_pkg::CFG_W'(128);
            r_ph    <= vmd_pkg::CFG_W'(128);
            r_pd    <= vmd_pkg::CFG_W'(128);
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_xpart <= '0;
            r_xodd  <= '0;
            r_s1    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vmd_pkg::REG_WIDTH:  r_pw <= i_cfg_data;
                    vmd_pkg::REG_HEIGHT: r_ph <= i_cfg_data;
                    vmd_pkg::REG_DEPTH:  r_pd <= i_cfg_data;
                    default:             r_pw <= r_pw;
                endcase
            end
            if (i_acc) begin
                r_px    <= n_px;
                r_py    <= n_py;
                r_pz    <= n_pz;
                r_xpart <= n_xpart;
                r_xodd  <= n_xodd;
            end
            if (i_adv) begin
                r_s1 <= n_s1;
            end
        end
    end

    assign o_rowrd.act = n_s1.act;
    assign o_rowrd.cx  = cx;
    assign o_s1        = r_s1;
endmodule

>>> hw/rtl/vmd_yz.sv
// ----------------------------------------------------------------------------
// vmd_yz
// y and z filter stages, read-modify-write on the row and plane stores
// ----------------------------------------------------------------------------
module vmd_yz (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  vmd_pkg::t_rowrd i_rowrd,
    input  vmd_pkg::t_s1    i_s1,
    output vmd_pkg::t_s3    o_s3
);
    logic                       row_we;
    logic [vmd_pkg::HY_W-1:0]   row_wdata, row_rdata, row_rd;
    logic                       pl_we;
    logic [vmd_pkg::SUM_W-1:0]  pl_wdata, pl_rdata, pl_rd;
    vmd_pkg::t_s2               r_s2, n_s2;
    vmd_pkg::t_s3               r_s3, n_s3;
    logic [vmd_pkg::HY_W-1:0]   hx_ext;
    logic [vmd_pkg::SUM_W-1:0]  hy_ext;
    logic                       r_row_fwd;
    logic [vmd_pkg::HY_W-1:0]   r_row_fwd_data;
    logic                       r_pl_fwd;
    logic [vmd_pkg::SUM_W-1:0]  r_pl_fwd_data;

    always_comb begin
        // write to the entry read in the same cycle is forwarded
        row_rd    = r_row_fwd ? r_row_fwd_data : row_rdata;
        pl_rd     = r_pl_fwd ? r_pl_fwd_data : pl_rdata;

        hx_ext    = vmd_pkg::HY_W'(i_s1.hx);
        row_we    = 1'b0;
        row_wdata = hx_ext;
        n_s2      = '0;
        n_s2.paddr = vmd_pkg::PA_W'(32'(i_s1.cy) * vmd_pkg::HALF_W + 32'(i_s1.cx));
        n_s2.cx   = i_s1.cx;
        n_s2.cy   = i_s1.cy;
        n_s2.cz   = i_s1.cz;
        n_s2.rz   = i_s1.rz;
        n_s2.z0   = i_s1.z0;
        n_s2.last = i_s1.last;
        case (i_s1.ry)
            vmd_pkg::ROLE_SINGLE: begin
                n_s2.hy  = hx_ext * vmd_pkg::HY_W'(5);
                n_s2.act = i_s1.act;
            end
            vmd_pkg::ROLE_EVEN: begin
                row_we    = i_s1.act;
                row_wdata = i_s1.y0 ? hx_ext << 2 : row_rd + hx_ext * vmd_pkg::HY_W'(3);
            end
            vmd_pkg::ROLE_ODD: begin
                row_we    = i_s1.act;
                row_wdata = hx_ext;
                n_s2.hy   = row_rd + hx_ext;
                n_s2.act  = i_s1.act;
            end
            default: begin
                row_we = 1'b0;
            end
        endcase

        hy_ext   = vmd_pkg::SUM_W'(r_s2.hy);
        pl_we    = 1'b0;
        pl_wdata = hy_ext;
        n_s3     = '0;
        n_s3.cx   = r_s2.cx;
        n_s3.cy   = r_s2.cy;
        n_s3.cz   = r_s2.cz;
        n_s3.last = r_s2.last;
        case (r_s2.rz)
            vmd_pkg::ROLE_SINGLE: begin
                n_s3.sum = hy_ext * vmd_pkg::SUM_W'(5);
                n_s3.act = r_s2.act;
            end
            vmd_pkg::ROLE_EVEN: begin
                pl_we    = r_s2.act;
                pl_wdata = r_s2.z0 ? hy_ext << 2 : pl_rd + hy_ext * vmd_pkg::SUM_W'(3);
            end
            vmd_pkg::ROLE_ODD: begin
                pl_we    = r_s2.act;
                pl_wdata = hy_ext;
                n_s3.sum = pl_rd + hy_ext;
                n_s3.act = r_s2.act;
            end
            default: begin
                pl_we = 1'b0;
            end
        endcase
    end

    vmd_ram #(.WIDTH(vmd_pkg::HY_W), .DEPTH(vmd_pkg::HALF_W)) u_row (
        .i_clk   (i_clk),
        .i_we    (row_we && i_adv),
        .i_waddr (i_s1.cx),
        .i_wdata (row_wdata),
        .i_re    (i_adv),
        .i_raddr (i_rowrd.cx),
        .o_rdata (row_rdata)
    );

    vmd_ram #(.WIDTH(vmd_pkg::SUM_W), .DEPTH(vmd_pkg::HALF_W * vmd_pkg::HALF_H)) u_plane (
        .i_clk   (i_clk),
        .i_we    (pl_we && i_adv),
        .i_waddr (r_s2.paddr),
        .i_wdata (pl_wdata),
        .i_re    (i_adv),
        .i_raddr (n_s2.paddr),
        .o_rdata (pl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2           <= '0;
            r_s3           <= '0;
            r_row_fwd      <= 1'b0;
            r_row_fwd_data <= '0;
            r_pl_fwd       <= 1'b0;
            r_pl_fwd_data  <= '0;
        end else if (i_adv) begin
            r_s2           <= n_s2;
            r_s3           <= n_s3;
            r_row_fwd      <= row_we && i_rowrd.act && (i_rowrd.cx == i_s1.cx);
            r_row_fwd_data <= row_wdata;
            r_pl_fwd       <= pl_we && n_s2.act && (n_s2.paddr == r_s2.paddr);
            r_pl_fwd_data  <= pl_wdata;
        end
    end

    assign o_s3 = r_s3;

    // a row write to the entry being read is forwarded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && row_we && i_rowrd.act && (i_rowrd.cx == i_s1.cx)) |=> r_row_fwd)
        else $error("row store write not forwarded");

    // a plane write to the entry being read is forwarded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && pl_we && n_s2.act && (n_s2.paddr == r_s2.paddr)) |=> r_pl_fwd)
        else $error("plane store write not forwarded");

    // a y sum finished on an odd row reaches the z stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_s1.act && i_s1.ry == vmd_pkg::ROLE_ODD) |=> r_s2.act)
        else $error("y sum lost");
endmodule

>>> hw/rtl/volume_mip_downsample_3d.sv
// ----------------------------------------------------------------------------
// volume_mip_downsample_3d
// 3d mip level downsampler, separable 1-3-1 filter, unless held one voxel per cycle
// ----------------------------------------------------------------------------
// parent voxels enter on i_in in raster order, x fastest; volume_start marks
// voxel (0,0,0). child voxels leave on o_out with their coordinates, the
// inverted byte and a last flag on the final child of the level.
// sizes are set on the cfg port (0 width, 1 height, 2 depth); the user
// must write them only while idle, the block does not enforce it. one
// parent voxel is taken every cycle unless the pipeline holds. a child
// passes x stage, row store stage, plane store stage, then divide by 125
// into the output register. each store is a ram with a registered read,
// read and written back once per cycle unless the pipeline holds; a write
// to the entry read in the same cycle is forwarded.
// input stays ready while a result waits in the output register; only when
// a further result reaches the last stage with the receiver stalled does
// the whole pipeline hold.
// after reset the sizes are 128 and the position is (0,0,0); the stores
// need no clearing, each entry is written before it is read.
// ----------------------------------------------------------------------------
module volume_mip_downsample_3d (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [vmd_pkg::CFG_W-1:0] i_cfg_data,
    vmd_in_if.sink                    i_in,
    vmd_out_if.source                 o_out
);
    logic                      adv, acc;
    vmd_pkg::t_rowrd           rowrd;
    vmd_pkg::t_s1              s1;
    vmd_pkg::t_s3              s3;
    logic [vmd_pkg::SUM_W+vmd_pkg::RCP_W-1:0] prod;
    logic [vmd_pkg::SUM_W+vmd_pkg::RCP_W-vmd_pkg::RSH-1:0] quot;
    logic [vmd_pkg::VAL_W-1:0] val;
    logic                      r_ov;
    logic [vmd_pkg::VAL_W-1:0] r_val;
    logic [vmd_pkg::COORD_W-1:0] r_x, r_y, r_z;
    logic                      r_last;

    assign adv = !(r_ov && !o_out.ready && s3.act);
    assign acc = i_in.valid && adv;
    assign i_in.ready = adv;

    vmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_adv      (adv),
        .i_voxel    (i_in.voxel),
        .i_start    (i_in.volume_start),
        .o_rowrd    (rowrd),
        .o_s1       (s1)
    );

    vmd_yz u_yz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_rowrd (rowrd),
        .i_s1    (s1),
        .o_s3    (s3)
    );

    // divide by 125 through the scaled reciprocal
    always_comb begin
        prod = (vmd_pkg::SUM_W + vmd_pkg::RCP_W)'(s3.sum) *
               (vmd_pkg::SUM_W + vmd_pkg::RCP_W)'(vmd_pkg::RECIP);
        quot = prod[vmd_pkg::SUM_W+vmd_pkg::RCP_W-1:vmd_pkg::RSH];
        val  = (quot > 9'd255) ? 8'd255 : quot[vmd_pkg::VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (adv && s3.act) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s3.act) begin
            r_val  <= val;
            r_x    <= vmd_pkg::COORD_W'(s3.cx);
            r_y    <= vmd_pkg::COORD_W'(s3.cy);
            r_z    <= vmd_pkg::COORD_W'(s3.cz);
            r_last <= s3.last;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.child_value    = r_val;
    assign o_out.inverted_value = 8'd255 - r_val;
    assign o_out.out_x          = r_x;
    assign o_out.out_y          = r_y;
    assign o_out.out_z          = r_z;
    assign o_out.last_of_volume = r_last;
endmodule

>>> sim/volume_mip_downsample_3d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_mip_downsample_3d_tb
// self-checking bench for the 3d mip level downsampler
// ----------------------------------------------------------------------------
// parent volumes of many shapes are streamed in raster order while both
// channels stall at random in some modes. a scoreboard mirrors the 1-3-1
// separable filter with its own running row and plane sums, predicts each
// child voxel and checks every field of every delivered child, in order.
// ----------------------------------------------------------------------------

typedef struct {
    bit [7:0] value;
    bit [7:0] inverted;
    bit [5:0] cx;
    bit [5:0] cy;
    bit [5:0] cz;
    bit       last;
} t_child_voxel;

class mip_scoreboard;
    bit [7:0]     size_reg [3];
    int unsigned  px, py, pz;
    int unsigned  x_part, x_odd;
    int unsigned  row_sum [vmd_pkg::HALF_W];
    int unsigned  plane_sum [vmd_pkg::HALF_W * vmd_pkg::HALF_H];
    t_child_voxel pending [$];
    int           errors;

    function new();
        size_reg = '{8'd128, 8'd128, 8'd128};
        px = 0;
        py = 0;
        pz = 0;
        x_part = 0;
        x_odd = 0;
        errors = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [7:0] data);
        if (idx == vmd_pkg::REG_WIDTH) size_reg[0] = data;
        else if (idx == vmd_pkg::REG_HEIGHT) size_reg[1] = data;
        else if (idx == vmd_pkg::REG_DEPTH) size_reg[2] = data;
    endfunction

    function int unsigned eff_size(bit [7:0] r, int unsigned lim);
        if (r == 0) return 1;
        return (r > lim) ? lim : r;
    endfunction

    function int unsigned half_size(int unsigned n);
        return (n / 2 == 0) ? 1 : n / 2;
    endfunction

    function vmd_pkg::t_role role_of(int unsigned p, int unsigned n,
                                     output int unsigned c);
        c = p / 2;
        if (n == 1) begin
            c = 0;
            return vmd_pkg::ROLE_SINGLE;
        end
        if (c >= half_size(n)) return vmd_pkg::ROLE_NONE;
        return p[0] ? vmd_pkg::ROLE_ODD : vmd_pkg::ROLE_EVEN;
    endfunction

    function bit at_origin();
        return px == 0 && py == 0 && pz == 0;
    endfunction

    function void note_request(bit [7:0] v, bit start);
        int unsigned    pw, ph, pd, cx, cy, cz, hx, hy, sum, val, idx;
        vmd_pkg::t_role rx, ry, rz;
        bit             x_done, y_done, emit;
        t_child_voxel   c;
        pw = eff_size(size_reg[0], vmd_pkg::MAX_WIDTH);
        ph = eff_size(size_reg[1], vmd_pkg::MAX_HEIGHT);
        pd = eff_size(size_reg[2], vmd_pkg::MAX_DEPTH);
        hx = 0;
        hy = 0;
        sum = 0;
        x_done = 0;
        y_done = 0;
        emit = 0;
        if (start) begin
            px = 0;
            py = 0;
            pz = 0;
        end
        if (px >= pw) px = 0;
        if (py >= ph) py = 0;
        if (pz >= pd) pz = 0;
        rx = role_of(px, pw, cx);
        ry = role_of(py, ph, cy);
        rz = role_of(pz, pd, cz);

        if (rx == vmd_pkg::ROLE_SINGLE) begin
            hx = 5 * v;
            x_done = 1;
        end else if (rx == vmd_pkg::ROLE_EVEN) begin
            x_part = (px == 0) ? 4 * v : x_odd + 3 * v;
        end else if (rx == vmd_pkg::ROLE_ODD) begin
            hx = x_part + v;
            x_odd = v;
            x_done = 1;
        end

        if (x_done && cx < vmd_pkg::HALF_W) begin
            if (ry == vmd_pkg::ROLE_SINGLE) begin
                hy = 5 * hx;
                y_done = 1;
            end else if (ry == vmd_pkg::ROLE_EVEN) begin
                row_sum[cx] = (py == 0) ? 4 * hx : row_sum[cx] + 3 * hx;
            end else if (ry == vmd_pkg::ROLE_ODD) begin
                hy = row_sum[cx] + hx;
                row_sum[cx] = hx;
                y_done = 1;
            end
        end

        if (y_done && cx < vmd_pkg::HALF_W && cy < vmd_pkg::HALF_H) begin
            idx = cy * vmd_pkg::HALF_W + cx;
            if (rz == vmd_pkg::ROLE_SINGLE) begin
                sum = 5 * hy;
                emit = 1;
            end else if (rz == vmd_pkg::ROLE_EVEN) begin
                plane_sum[idx] = (pz == 0) ? 4 * hy : plane_sum[idx] + 3 * hy;
            end else if (rz == vmd_pkg::ROLE_ODD) begin
                sum = plane_sum[idx] + hy;
                plane_sum[idx] = hy;
                emit = 1;
            end
        end

        if (emit) begin
            val = sum / 125;
            if (val > 255) val = 255;
            c.value = val[7:0];
            c.inverted = 8'd255 - val[7:0];
            c.cx = cx[5:0];
            c.cy = cy[5:0];
            c.cz = cz[5:0];
            c.last = (cx == half_size(pw) - 1) && (cy == half_size(ph) - 1) &&
                     (cz == half_size(pd) - 1);
            pending = {pending, c};
        end

        if (px + 1 < pw) px++;
        else begin
            px = 0;
            if (py + 1 < ph) py++;
            else begin
                py = 0;
                if (pz + 1 < pd) pz++;
                else pz = 0;
            end
        end
    endfunction

    function void check_child(t_child_voxel got);
        t_child_voxel exp_c;
        if (pending.size() == 0) begin
            $display("%0t: unexpected child value=%0d at (%0d,%0d,%0d)",
                     $time, got.value, got.cx, got.cy, got.cz);
            errors++;
            return;
        end
        exp_c = pending.pop_front();
        if (got != exp_c) begin
            $display("%0t: child mismatch expected val=%0d inv=%0d (%0d,%0d,%0d) last=%0d",
                     $time, exp_c.value, exp_c.inverted, exp_c.cx, exp_c.cy, exp_c.cz,
                     exp_c.last);
            $display("%0t:                actual   val=%0d inv=%0d (%0d,%0d,%0d) last=%0d",
                     $time, got.value, got.inverted, got.cx, got.cy, got.cz, got.last);
            errors++;
        end
    endfunction
endclass

module volume_mip_downsample_3d_tb;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [vmd_pkg::CFG_W-1:0] i_cfg_data;

    vmd_in_if  in_ch ();
    vmd_out_if out_ch ();

    volume_mip_downsample_3d uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    mip_scoreboard sb = new();

    int send_idle = 0;
    int recv_idle = 0;
    bit hold_req  = 0;
    int hold_left = 0;
    int stall_cnt = 0;
    int sent      = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver side
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) out_ch.ready = 1'b0;
        else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready = 1'b0;
        end else out_ch.ready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_child_voxel got;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_request(in_ch.voxel, in_ch.volume_start);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.value = out_ch.child_value;
            got.inverted = out_ch.inverted_value;
            got.cx = out_ch.out_x;
            got.cy = out_ch.out_y;
            got.cz = out_ch.out_z;
            got.last = out_ch.last_of_volume;
            sb.check_child(got);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_size(logic [7:0] w, logic [7:0] h, logic [7:0] d);
        wait_drained();
        write_reg(vmd_pkg::REG_WIDTH, w);
        write_reg(vmd_pkg::REG_HEIGHT, h);
        write_reg(vmd_pkg::REG_DEPTH, d);
    endtask

    task automatic send_voxel(logic [7:0] v, logic start);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.voxel = v;
        in_ch.volume_start = start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    // fill: 0 random, 1 all zero, 2 all ones
    task automatic send_volume(int n, int fill, bit flag_start);
        logic [7:0] v;
        for (int k = 0; k < n; k++) begin
            v = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom_range(255));
            send_voxel(v, (k == 0) && flag_start);
        end
        in_ch.valid = 1'b0;
    endtask

    function automatic int volume_len();
        return sb.eff_size(sb.size_reg[0], vmd_pkg::MAX_WIDTH) *
               sb.eff_size(sb.size_reg[1], vmd_pkg::MAX_HEIGHT) *
               sb.eff_size(sb.size_reg[2], vmd_pkg::MAX_DEPTH);
    endfunction

    function automatic logic [7:0] pick_size();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'($urandom_range(7, 20));
        return 8'($urandom_range(1, 4));
    endfunction

    initial begin
        int n;
        bit cont;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = vmd_pkg::REG_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.voxel = '0;
        in_ch.volume_start = 1'b0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        set_size(8'd2, 8'd2, 8'd2);
        send_volume(8, 2, 1);
        send_volume(8, 1, 0);
        send_volume(8, 0, 0);
        set_size(8'd0, 8'd0, 8'd0);
        send_volume(1, 2, 1);
        send_volume(2, 0, 0);
        set_size(8'd3, 8'd5, 8'd3);
        send_volume(45, 0, 1);
        send_volume(7, 0, 1);
        send_volume(45, 2, 1);
        set_size(8'd255, 8'd1, 8'd1);
        send_volume(128, 0, 1);
        set_size(8'd1, 8'd8, 8'd1);
        send_volume(8, 0, 1);
        set_size(8'd1, 8'd1, 8'd8);
        send_volume(8, 0, 1);
        wait_drained();
        write_reg(2'd3, 8'd5);

        // long receiver hold-off while requests keep coming
        set_size(8'd4, 8'd2, 8'd2);
        @(posedge i_clk);
        hold_req = 1;
        @(negedge i_clk);
        for (int k = 0; k < 5; k++) send_volume(16, 0, k == 0);

        // random part in three idling modes
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            send_idle = (ph == 0) ? 7 : (ph == 1) ? 61 : 0;
            recv_idle = (ph == 0) ? 61 : (ph == 1) ? 7 : 0;
            n = sent + 40;
            cont = 0;
            while (sent < n) begin
                if (!cont || $urandom_range(2) == 0) begin
                    set_size(pick_size(), pick_size(), pick_size());
                    cont = 0;
                end
                if ($urandom_range(7) == 0) begin
                    send_volume($urandom_range(1, volume_len()), 0, 1);
                    cont = 0;
                end else begin
                    send_volume(volume_len(), 0, !(cont && sb.at_origin()) ||
                                $urandom_range(1));
                    cont = 1;
                end
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
